/* rtl/snt_pkg.sv */
// ----------------------------------------------------------------------------
// snt_pkg
// Shared widths, op codes and cell control type for the sorted neighbor table.
// ----------------------------------------------------------------------------
package snt_pkg;

    localparam int ID_W        = 8;
    localparam int PWR_W       = 3;
    localparam int OP_W        = 3;
    localparam int TABLE_DEPTH = 8;

    localparam logic [PWR_W-1:0] MAX_POWER = 3'd4;

    // op codes
    localparam logic [OP_W-1:0] OP_PING   = 3'd0;
    localparam logic [OP_W-1:0] OP_ACK    = 3'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP = 3'd2;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

    // control broadcast to every cell of one table
    typedef struct packed {
        logic             ins;   // insert key unless already present
        logic             rm;    // remove front entry, shift toward front
        logic             clr;   // clear all entries
        logic             asc;   // 1: ascending order, 0: descending
        logic [ID_W-1:0]  key;
        logic [PWR_W-1:0] pwr;
    } ctl_t;

endpackage

/* rtl/sorted_neighbour_table.sv */
// ----------------------------------------------------------------------------
// sorted_neighbour_table
// Upper and lower sorted neighbor tables with ping/ack insert, light-on
// lookup, nearest removal and clear.
// ----------------------------------------------------------------------------
//  channel   | handshake          | payload
//  ----------+--------------------+----------------------------------------------
//  config    | cfg_we             | cfg_wdata (node id)
//  command   | start, busy        | op, source_id, dest_id, power_level, side
//  result    | result_valid       | send_ack, ack_power, found, inserted,
//            |                    | nearest_upper, nearest_lower
//
//  One item per cycle; each result shows in the cycle after its item is taken.
//  The cell row updates on each accepted item, so busy is always low.
//  Reset clears both tables, node id and the result strobe.
//  The receiver cannot stall: each result is shown on result_valid for exactly one cycle.
// ----------------------------------------------------------------------------
module sorted_neighbour_table
#(
    parameter int TABLE_DEPTH = snt_pkg::TABLE_DEPTH
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    // config
    input  logic                      cfg_we,
    input  logic [snt_pkg::ID_W-1:0]  cfg_wdata,
    // command
    input  logic                      start,
    output logic                      busy,
    input  logic [snt_pkg::OP_W-1:0]  op,
    input  logic [snt_pkg::ID_W-1:0]  source_id,
    input  logic [snt_pkg::ID_W-1:0]  dest_id,
    input  logic [snt_pkg::PWR_W-1:0] power_level,
    input  logic                      side,
    // result
    output logic                      result_valid,
    output logic                      send_ack,
    output logic [snt_pkg::PWR_W-1:0] ack_power,
    output logic                      found,
    output logic                      inserted,
    output logic [snt_pkg::ID_W-1:0]  nearest_upper,
    output logic [snt_pkg::ID_W-1:0]  nearest_lower
);

    logic [snt_pkg::ID_W-1:0]  node_id_reg;
    logic                      valid_reg;
    logic                      send_ack_reg;
    logic                      send_ack_next;
    logic [snt_pkg::PWR_W-1:0] ack_power_reg;
    logic [snt_pkg::PWR_W-1:0] ack_power_next;
    logic                      found_reg;
    logic                      found_next;
    logic                      inserted_reg;
    logic                      inserted_next;

    logic                      accept;
    logic                      up;
    logic                      src_ok;
    logic                      is_ins;
    logic [snt_pkg::PWR_W-1:0] pwr_sat;
    snt_pkg::ctl_t             ctl_up;
    snt_pkg::ctl_t             ctl_lo;
    logic                      f_up;
    logic                      f_lo;
    logic [snt_pkg::PWR_W-1:0] fpw_up;
    logic [snt_pkg::PWR_W-1:0] fpw_lo;
    logic                      ins_up;
    logic                      ins_lo;
    logic                      hit;
    logic [snt_pkg::PWR_W-1:0] hit_pw;
    logic                      hit_ins;

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // command decode
    assign up      = source_id > node_id_reg;
    assign src_ok  = source_id != '0;
    assign is_ins  = (op == snt_pkg::OP_PING) || (op == snt_pkg::OP_ACK);
    assign pwr_sat = (power_level > snt_pkg::MAX_POWER) ? snt_pkg::MAX_POWER
                                                        : power_level;

    always_comb
    begin
        ctl_up.ins = accept & is_ins & src_ok & up;
        ctl_up.rm  = accept & (op == snt_pkg::OP_REMOVE) & side;
        ctl_up.clr = accept & (op == snt_pkg::OP_CLEAR);
        ctl_up.asc = 1'b1;
        ctl_up.key = source_id;
        ctl_up.pwr = pwr_sat;

        ctl_lo.ins = accept & is_ins & src_ok & ~up;
        ctl_lo.rm  = accept & (op == snt_pkg::OP_REMOVE) & ~side;
        ctl_lo.clr = accept & (op == snt_pkg::OP_CLEAR);
        ctl_lo.asc = 1'b0;
        ctl_lo.key = source_id;
        ctl_lo.pwr = pwr_sat;
    end

    snt_table #(.TABLE_DEPTH(TABLE_DEPTH)) u_upper
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl_up),
        .found    (f_up),
        .found_pw (fpw_up),
        .inserted (ins_up),
        .head_id  (nearest_upper)
    );

    snt_table #(.TABLE_DEPTH(TABLE_DEPTH)) u_lower
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl_lo),
        .found    (f_lo),
        .found_pw (fpw_lo),
        .inserted (ins_lo),
        .head_id  (nearest_lower)
    );

    assign hit     = up ? f_up : f_lo;
    assign hit_pw  = up ? fpw_up : fpw_lo;
    assign hit_ins = up ? ins_up : ins_lo;

    // result flags
    always_comb
    begin
        send_ack_next  = 1'b0;
        ack_power_next = '0;
        found_next     = 1'b0;
        inserted_next  = 1'b0;
        if (src_ok)
        begin
            case (op)
                snt_pkg::OP_PING:
                begin
                    send_ack_next  = 1'b1;
                    found_next     = hit;
                    ack_power_next = hit ? hit_pw : pwr_sat;
                    inserted_next  = hit_ins;
                end
                snt_pkg::OP_ACK:
                begin
                    found_next    = hit;
                    inserted_next = hit_ins;
                end
                snt_pkg::OP_LOOKUP:
                begin
                    if (dest_id == node_id_reg)
                    begin
                        send_ack_next  = 1'b1;
                        found_next     = hit;
                        ack_power_next = hit ? hit_pw : '0;
                    end
                end
                default:
                begin
                    send_ack_next = 1'b0;
                end
            endcase
        end
    end

    // config and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_id_reg <= '0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                node_id_reg <= cfg_wdata;
            end
            valid_reg <= accept;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            send_ack_reg  <= send_ack_next;
            ack_power_reg <= ack_power_next;
            found_reg     <= found_next;
            inserted_reg  <= inserted_next;
        end
    end

    assign result_valid = valid_reg;
    assign send_ack     = send_ack_reg;
    assign ack_power    = ack_power_reg;
    assign found        = found_reg;
    assign inserted     = inserted_reg;

endmodule

/* rtl/snt_cell.sv */
// ----------------------------------------------------------------------------
// snt_cell
// One table slot: holds an id and power, compares against the key and takes
// its neighbor's entry on a shift.
// ----------------------------------------------------------------------------
module snt_cell
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  snt_pkg::ctl_t             ctl,
    input  logic                      ins_en,      // insert allowed (key not found)
    // neighbor toward the front
    input  logic                      prev_cond,
    input  logic [snt_pkg::ID_W-1:0]  prev_id,
    input  logic [snt_pkg::PWR_W-1:0] prev_pw,
    // neighbor toward the back
    input  logic [snt_pkg::ID_W-1:0]  nxt_id,
    input  logic [snt_pkg::PWR_W-1:0] nxt_pw,
    // match accumulation along the row
    input  logic                      found_in,
    input  logic [snt_pkg::PWR_W-1:0] fpw_in,
    output logic                      found_out,
    output logic [snt_pkg::PWR_W-1:0] fpw_out,
    // this slot
    output logic                      cond,
    output logic [snt_pkg::ID_W-1:0]  id,
    output logic [snt_pkg::PWR_W-1:0] pw
);

    logic [snt_pkg::ID_W-1:0]  id_reg;
    logic [snt_pkg::ID_W-1:0]  id_next;
    logic [snt_pkg::PWR_W-1:0] pw_reg;
    logic [snt_pkg::PWR_W-1:0] pw_next;
    logic                      match;

    // key goes at or before this slot
    assign cond  = (id_reg == '0) ||
                   (ctl.asc ? (ctl.key < id_reg) : (ctl.key > id_reg));
    assign match = (id_reg == ctl.key);

    assign found_out = found_in | match;
    assign fpw_out   = fpw_in | (match ? pw_reg : '0);

    // slot update
    always_comb
    begin
        id_next = id_reg;
        pw_next = pw_reg;
        if (ctl.clr)
        begin
            id_next = '0;
            pw_next = '0;
        end
        else if (ctl.rm)
        begin
            id_next = nxt_id;
            pw_next = nxt_pw;
        end
        else if (ctl.ins && ins_en)
        begin
            if (prev_cond)
            begin
                id_next = prev_id;
                pw_next = prev_pw;
            end
            else if (cond)
            begin
                id_next = ctl.key;
                pw_next = ctl.pwr;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_reg <= '0;
            pw_reg <= '0;
        end
        else
        begin
            id_reg <= id_next;
            pw_reg <= pw_next;
        end
    end

    assign id = id_reg;
    assign pw = pw_reg;

endmodule

/* rtl/snt_table.sv */
// ----------------------------------------------------------------------------
// snt_table
// A row of cells forming one sorted, front-packed table.
// ----------------------------------------------------------------------------
module snt_table
#(
    parameter int TABLE_DEPTH = snt_pkg::TABLE_DEPTH
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  snt_pkg::ctl_t             ctl,
    output logic                      found,
    output logic [snt_pkg::PWR_W-1:0] found_pw,
    output logic                      inserted,
    output logic [snt_pkg::ID_W-1:0]  head_id
);

    logic                      cond_w   [TABLE_DEPTH];
    logic [snt_pkg::ID_W-1:0]  id_w     [TABLE_DEPTH];
    logic [snt_pkg::PWR_W-1:0] pw_w     [TABLE_DEPTH];
    logic                      found_w  [TABLE_DEPTH+1];
    logic [snt_pkg::PWR_W-1:0] fpw_w    [TABLE_DEPTH+1];
    logic                      ins_en;

    assign found_w[0] = 1'b0;
    assign fpw_w[0]   = '0;
    assign found      = found_w[TABLE_DEPTH];
    assign found_pw   = fpw_w[TABLE_DEPTH];
    assign ins_en     = ~found;

    // table is packed and sorted, so the back slot's cond says a place exists
    assign inserted   = ctl.ins & ins_en & cond_w[TABLE_DEPTH-1];
    assign head_id    = id_w[0];

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        logic                      p_cond;
        logic [snt_pkg::ID_W-1:0]  p_id;
        logic [snt_pkg::PWR_W-1:0] p_pw;
        logic [snt_pkg::ID_W-1:0]  n_id;
        logic [snt_pkg::PWR_W-1:0] n_pw;

        if (i == 0)
        begin : g_front
            assign p_cond = 1'b0;
            assign p_id   = '0;
            assign p_pw   = '0;
        end
        else
        begin : g_mid
            assign p_cond = cond_w[i-1];
            assign p_id   = id_w[i-1];
            assign p_pw   = pw_w[i-1];
        end

        if (i == TABLE_DEPTH - 1)
        begin : g_back
            assign n_id = '0;
            assign n_pw = '0;
        end
        else
        begin : g_inner
            assign n_id = id_w[i+1];
            assign n_pw = pw_w[i+1];
        end

        snt_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .ins_en    (ins_en),
            .prev_cond (p_cond),
            .prev_id   (p_id),
            .prev_pw   (p_pw),
            .nxt_id    (n_id),
            .nxt_pw    (n_pw),
            .found_in  (found_w[i]),
            .fpw_in    (fpw_w[i]),
            .found_out (found_w[i+1]),
            .fpw_out   (fpw_w[i+1]),
            .cond      (cond_w[i]),
            .id        (id_w[i]),
            .pw        (pw_w[i])
        );
    end

endmodule

/* verif/sorted_neighbour_table_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_neighbour_table_test
// Self-checking bench for the sorted neighbor table. A scoreboard object
// keeps its own copy of both tables and of the node id, predicts each result
// from the accepted command items, and compares every result strobe field by
// field. Directed items hit the corner cases, then random traffic, mostly
// ping/ack/lookup over ids near the node id, runs under several node id settings.
// ----------------------------------------------------------------------------

typedef struct packed {
    logic                      send_ack;
    logic [snt_pkg::PWR_W-1:0] ack_power;
    logic                      found;
    logic                      inserted;
    logic [snt_pkg::ID_W-1:0]  nearest_upper;
    logic [snt_pkg::ID_W-1:0]  nearest_lower;
} table_result_t;

// table index inside the scoreboard: 0 lower, 1 upper
class neighbour_table_scoreboard;
    logic [snt_pkg::ID_W-1:0]  node_id;
    logic [snt_pkg::ID_W-1:0]  ids  [2][snt_pkg::TABLE_DEPTH];
    logic [snt_pkg::PWR_W-1:0] pows [2][snt_pkg::TABLE_DEPTH];
    table_result_t             expected_results[$];
    int                        checked;
    int                        mismatches;

    function new();
        node_id    = '0;
        checked    = 0;
        mismatches = 0;
        wipe_tables();
    endfunction

    function void wipe_tables();
        for (int t = 0; t < 2; t++)
            for (int i = 0; i < snt_pkg::TABLE_DEPTH; i++)
            begin
                ids[t][i]  = '0;
                pows[t][i] = '0;
            end
    endfunction

    function void write_node_id(logic [snt_pkg::ID_W-1:0] value);
        node_id = value;
    endfunction

    function int find_id(int t, logic [snt_pkg::ID_W-1:0] id);
        for (int i = 0; i < snt_pkg::TABLE_DEPTH; i++)
            if (ids[t][i] == id)
                return i;
        return -1;
    endfunction

    // sorted insert, ascending in the upper table, descending in the lower
    function bit place_entry(int t, logic [snt_pkg::ID_W-1:0] id,
                             logic [snt_pkg::PWR_W-1:0] p);
        int pos;
        bit stop;
        pos  = 0;
        stop = 0;
        while (!stop && pos < snt_pkg::TABLE_DEPTH)
        begin
            if (ids[t][pos] == '0)
                stop = 1;
            else if (t == 1 ? (id < ids[t][pos]) : (id > ids[t][pos]))
                stop = 1;
            else
                pos++;
        end
        if (pos >= snt_pkg::TABLE_DEPTH)
            return 0;
        for (int j = snt_pkg::TABLE_DEPTH - 1; j > pos; j--)
        begin
            ids[t][j]  = ids[t][j-1];
            pows[t][j] = pows[t][j-1];
        end
        ids[t][pos]  = id;
        pows[t][pos] = p;
        return 1;
    endfunction

    function void drop_front(int t);
        for (int i = 0; i < snt_pkg::TABLE_DEPTH - 1; i++)
        begin
            ids[t][i]  = ids[t][i+1];
            pows[t][i] = pows[t][i+1];
        end
        ids[t][snt_pkg::TABLE_DEPTH-1]  = '0;
        pows[t][snt_pkg::TABLE_DEPTH-1] = '0;
    endfunction

    // accepted command item: update the tables, queue the expected result
    function void note_item(logic [snt_pkg::OP_W-1:0] opc, logic [snt_pkg::ID_W-1:0] src,
                            logic [snt_pkg::ID_W-1:0] dst,
                            logic [snt_pkg::PWR_W-1:0] pwr_in, logic sd);
        table_result_t              r;
        logic [snt_pkg::PWR_W-1:0]  pwr;
        int                         t;
        int                         idx;
        r   = '0;
        pwr = (pwr_in > snt_pkg::MAX_POWER) ? snt_pkg::MAX_POWER : pwr_in;
        t   = (src > node_id) ? 1 : 0;
        if (opc <= snt_pkg::OP_LOOKUP && src != '0)
        begin
            idx = find_id(t, src);
            if (opc == snt_pkg::OP_PING)
            begin
                r.send_ack = 1'b1;
                if (idx >= 0)
                begin
                    r.found     = 1'b1;
                    r.ack_power = pows[t][idx];
                end
                else
                begin
                    r.inserted  = place_entry(t, src, pwr);
                    r.ack_power = pwr;
                end
            end
            else if (opc == snt_pkg::OP_ACK)
            begin
                if (idx >= 0)
                    r.found = 1'b1;
                else
                    r.inserted = place_entry(t, src, pwr);
            end
            else if (dst == node_id)
            begin
                r.send_ack = 1'b1;
                if (idx >= 0)
                begin
                    r.found     = 1'b1;
                    r.ack_power = pows[t][idx];
                end
            end
        end
        else if (opc == snt_pkg::OP_REMOVE)
            drop_front(sd ? 1 : 0);
        else if (opc == snt_pkg::OP_CLEAR)
            wipe_tables();
        r.nearest_upper = ids[1][0];
        r.nearest_lower = ids[0][0];
        expected_results.push_back(r);
    endfunction

    function void check_result(table_result_t got);
        table_result_t want;
        bit            bad;
        if (expected_results.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: result with nothing pending: %p", got);
            return;
        end
        want = expected_results.pop_front();
        checked++;
        bad = (got.send_ack      !== want.send_ack)      ||
              (got.ack_power     !== want.ack_power)     ||
              (got.found         !== want.found)         ||
              (got.inserted      !== want.inserted)      ||
              (got.nearest_upper !== want.nearest_upper) ||
              (got.nearest_lower !== want.nearest_lower);
        if (bad)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("ERROR: result %0d mismatch", checked);
                $display("  expected ack=%0d pwr=%0d found=%0d ins=%0d up=%0d low=%0d",
                         want.send_ack, want.ack_power, want.found, want.inserted,
                         want.nearest_upper, want.nearest_lower);
                $display("  actual   ack=%0d pwr=%0d found=%0d ins=%0d up=%0d low=%0d",
                         got.send_ack, got.ack_power, got.found, got.inserted,
                         got.nearest_upper, got.nearest_lower);
            end
        end
    endfunction
endclass

module sorted_neighbour_table_test;

    localparam int              ID_W           = snt_pkg::ID_W;
    localparam int              PWR_W          = snt_pkg::PWR_W;
    localparam int              OP_W           = snt_pkg::OP_W;
    localparam int              CYCLE_LIMIT    = 200000;
    localparam int              DRAIN_CYCLES   = 3;
    localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;
    localparam logic            SIDE_LOWER     = 1'b0;
    localparam logic            SIDE_UPPER     = 1'b1;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [ID_W-1:0]   cfg_wdata;
    logic              start;
    logic              busy;
    logic [OP_W-1:0]   op;
    logic [ID_W-1:0]   source_id;
    logic [ID_W-1:0]   dest_id;
    logic [PWR_W-1:0]  power_level;
    logic              side;
    logic              result_valid;
    logic              send_ack;
    logic [PWR_W-1:0]  ack_power;
    logic              found;
    logic              inserted;
    logic [ID_W-1:0]   nearest_upper;
    logic [ID_W-1:0]   nearest_lower;

    neighbour_table_scoreboard sb = new();
    logic [ID_W-1:0]           cur_node;
    int                        items_sent;
    int                        node_settings;
    int                        cycle_count;

    sorted_neighbour_table uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .start         (start),
        .busy          (busy),
        .op            (op),
        .source_id     (source_id),
        .dest_id       (dest_id),
        .power_level   (power_level),
        .side          (side),
        .result_valid  (result_valid),
        .send_ack      (send_ack),
        .ack_power     (ack_power),
        .found         (found),
        .inserted      (inserted),
        .nearest_upper (nearest_upper),
        .nearest_lower (nearest_lower)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Verification failed");
            $finish;
        end
    end

    // monitor: results first, then the accepted item, then config writes
    always @(posedge clk)
    begin : monitor
        table_result_t seen;
        if (rst_n)
        begin
            if (result_valid)
            begin
                seen.send_ack      = send_ack;
                seen.ack_power     = ack_power;
                seen.found         = found;
                seen.inserted      = inserted;
                seen.nearest_upper = nearest_upper;
                seen.nearest_lower = nearest_lower;
                sb.check_result(seen);
            end
            if (start && !busy)
                sb.note_item(op, source_id, dest_id, power_level, side);
            if (cfg_we)
                sb.write_node_id(cfg_wdata);
        end
    end

    // drive one command item and hold it until taken
    task automatic issue_item(input logic [OP_W-1:0] opc, input logic [ID_W-1:0] src,
                              input logic [ID_W-1:0] dst, input logic [PWR_W-1:0] pwr,
                              input logic sd);
        bit taken;
        start       <= 1'b1;
        op          <= opc;
        source_id   <= src;
        dest_id     <= dst;
        power_level <= pwr;
        side        <= sd;
        do
        begin
            @(negedge clk);
            taken = !busy;
            @(posedge clk);
        end
        while (!taken);
        items_sent++;
    endtask

    // wait for every pending result, then let the block settle
    task automatic drain();
        start <= 1'b0;
        @(negedge clk);
        while (sb.expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_node(input logic [ID_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        cur_node  = value;
        node_settings++;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // random traffic: mostly ping/ack/lookup over ids near the node id
    task automatic random_phase(input int count, input bit with_idle);
        logic [OP_W-1:0]  opc;
        logic [ID_W-1:0]  src;
        logic [ID_W-1:0]  dst;
        int               roll;
        int               near;
        bit               quiet;
        quiet = 0;
        for (int k = 0; k < count; k++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 30)
                opc = snt_pkg::OP_PING;
            else if (roll < 55)
                opc = snt_pkg::OP_ACK;
            else if (roll < 75)
                opc = snt_pkg::OP_LOOKUP;
            else if (roll < 87)
                opc = snt_pkg::OP_REMOVE;
            else if (roll < 90)
                opc = snt_pkg::OP_CLEAR;
            else
                opc = OP_W'($urandom_range(0, 7));
            if ($urandom_range(0, 3) != 0)
            begin
                near = int'(cur_node) + int'($urandom_range(0, 24)) - 12;
                if (near < 0)
                    near = 0;
                if (near > 255)
                    near = 255;
                src = ID_W'(near);
            end
            else
                src = ID_W'($urandom_range(0, 255));
            if ($urandom_range(0, 4) != 0)
                dst = cur_node;
            else
                dst = ID_W'($urandom_range(0, 255));
            issue_item(opc, src, dst, PWR_W'($urandom_range(0, 7)),
                       1'($urandom_range(0, 1)));
            // sender gaps come in bursts, with quiet stretches in between
            if (with_idle)
            begin
                if (k % 64 == 0)
                    quiet = ($urandom_range(0, 2) == 0);
                if (!quiet && $urandom_range(0, 3) == 0)
                begin
                    start <= 1'b0;
                    repeat ($urandom_range(1, 8)) @(posedge clk);
                end
            end
        end
    endtask

    // main sequence
    initial
    begin
        items_sent    = 0;
        node_settings = 0;
        cur_node      = '0;
        rst_n       <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_wdata   <= '0;
        start       <= 1'b0;
        op          <= snt_pkg::OP_PING;
        source_id   <= '0;
        dest_id     <= '0;
        power_level <= '0;
        side        <= SIDE_LOWER;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed corner cases around node id 100
        write_node(8'd100);
        issue_item(snt_pkg::OP_PING,   8'd0,   8'd100, 3'd3, SIDE_LOWER);  // source zero
        issue_item(snt_pkg::OP_PING,   8'd255, 8'd0,   3'd7, SIDE_LOWER);  // power saturates
        issue_item(snt_pkg::OP_PING,   8'd1,   8'd0,   3'd0, SIDE_UPPER);
        issue_item(snt_pkg::OP_PING,   8'd100, 8'd0,   3'd3, SIDE_LOWER);  // equal id goes low
        issue_item(snt_pkg::OP_PING,   8'd255, 8'd0,   3'd2, SIDE_LOWER);  // known, stored power
        issue_item(snt_pkg::OP_ACK,    8'd101, 8'd255, 3'd1, SIDE_LOWER);
        issue_item(snt_pkg::OP_ACK,    8'd101, 8'd0,   3'd5, SIDE_UPPER);  // known, no change
        issue_item(snt_pkg::OP_LOOKUP, 8'd255, 8'd100, 3'd0, SIDE_LOWER);  // hit
        issue_item(snt_pkg::OP_LOOKUP, 8'd50,  8'd100, 3'd7, SIDE_LOWER);  // miss, power 0
        issue_item(snt_pkg::OP_LOOKUP, 8'd255, 8'd99,  3'd0, SIDE_LOWER);  // not for us
        issue_item(snt_pkg::OP_LOOKUP, 8'd0,   8'd100, 3'd0, SIDE_LOWER);  // source zero
        issue_item(snt_pkg::OP_REMOVE, 8'd0,   8'd0,   3'd0, SIDE_UPPER);
        issue_item(snt_pkg::OP_REMOVE, 8'd0,   8'd0,   3'd0, SIDE_LOWER);
        issue_item(snt_pkg::OP_CLEAR,  8'd0,   8'd0,   3'd0, SIDE_LOWER);
        issue_item(snt_pkg::OP_REMOVE, 8'd0,   8'd0,   3'd0, SIDE_LOWER);  // empty table
        for (int u = OP_SPARE_FIRST; u <= OP_SPARE_LAST; u++)
            issue_item(OP_W'(u), 8'd120, 8'd100, 3'd2, SIDE_UPPER);
        // fill the upper table, then overflow beyond and inside its range
        for (int f = 0; f < snt_pkg::TABLE_DEPTH + 1; f++)
            issue_item(snt_pkg::OP_ACK, ID_W'(110 + 10 * f), 8'd0, PWR_W'(f % 5),
                       SIDE_UPPER);
        issue_item(snt_pkg::OP_PING, 8'd105, 8'd0, 3'd2, SIDE_UPPER);  // drops the farthest
        issue_item(snt_pkg::OP_PING, 8'd250, 8'd0, 3'd1, SIDE_UPPER);  // farthest, not stored
        drain();

        // random phases under several node ids; the last one without gaps
        write_node(8'd0);
        random_phase(200, 1);
        drain();
        write_node(8'd255);
        random_phase(200, 1);
        drain();
        write_node(8'd128);
        random_phase(200, 1);
        drain();
        write_node(ID_W'($urandom_range(1, 254)));
        random_phase(200, 1);
        drain();
        write_node(ID_W'($urandom_range(0, 255)));
        random_phase(200, 0);
        drain();

        $display("Sent %0d command items under %0d node id settings", items_sent,
                 node_settings);
        $display("Checked %0d results, %0d mismatches, %0d still pending", sb.checked,
                 sb.mismatches, sb.expected_results.size());
        if (sb.mismatches == 0 && sb.expected_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* sorted_neighbour_table.f */
rtl/snt_pkg.sv
rtl/snt_cell.sv
rtl/snt_table.sv
rtl/sorted_neighbour_table.sv
verif/sorted_neighbour_table_test.sv
